[hw/rtl/b128vc_pkg.sv]
package b128vc_pkg;

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam int GROUP_BITS = 7;
    localparam int VALUE_BITS = 63;
    localparam int GROUPS     = 9;

    typedef struct packed {
        logic                  op;
        logic [VALUE_BITS-1:0] value_in;
        logic [7:0]            byte_in;
    } b128vc_in_t;

    typedef struct packed {
        logic [1:0]            kind;
        logic [7:0]            byte_out;
        logic [VALUE_BITS-1:0] value_out;
        logic [3:0]            length;
        logic                  last;
    } b128vc_out_t;

endpackage

[hw/rtl/base128_varint_codec_top.sv]
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  b128vc_in_t  (op, value_in, byte_in)
// rsp       out        rsp_valid/rsp_ready  b128vc_out_t (kind, byte_out, value_out, length, last)
//
// A decode transaction takes a single step in the work register; an encode transaction
// takes one step per emitted byte (1 to 9), set by the byte-serial shift of the value.
// Results pass from the work register through one output register.
// Reset clears the decode accumulator, the byte count and all valid flags.
// A stall on rsp holds only steps that produce a result; continuing decode bytes proceed.
module base128_varint_codec_top #(
    parameter int MAX_BYTES = 9
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  b128vc_pkg::b128vc_in_t  req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output b128vc_pkg::b128vc_out_t rsp
);
    import b128vc_pkg::*;

    localparam logic [3:0] MAX_LEN = 4'(MAX_BYTES);

    logic                  work_valid_reg, work_valid_next;
    logic                  work_op_reg, work_op_next;
    logic                  work_err_reg, work_err_next;
    logic [VALUE_BITS-1:0] work_val_reg, work_val_next;
    logic [7:0]            work_byte_reg, work_byte_next;
    logic [3:0]            work_len_reg, work_len_next;
    logic [3:0]            work_left_reg, work_left_next;

    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic [3:0]            cnt_reg, cnt_next;

    logic                  out_valid_reg, out_valid_next;
    b128vc_out_t           out_reg, out_next;

    logic [3:0]            enc_len;
    logic                  enc_err;
    logic                  out_free;
    logic                  step_emits;
    logic                  step_done;
    logic                  step_go;
    logic                  accept;
    logic                  dec_full;
    logic [6:0]            dec_shift;
    logic [VALUE_BITS+6:0] dec_wide;
    logic [VALUE_BITS-1:0] dec_acc;
    logic [3:0]            dec_cnt;
    b128vc_out_t           result;

    always_comb
    begin
        enc_len = 4'd1;
        for (int g = 1; g < GROUPS; g++)
        begin
            if (req.value_in[GROUP_BITS*g +: GROUP_BITS] != 7'd0)
            begin
                enc_len = 4'(g + 1);
            end
        end
        enc_err = enc_len > MAX_LEN;
    end

    assign dec_full  = cnt_reg >= MAX_LEN;
    assign dec_shift = {cnt_reg, 3'b000} - {3'b000, cnt_reg};
    assign dec_wide  = (VALUE_BITS+7)'(work_byte_reg[6:0]) << dec_shift;
    assign dec_acc   = acc_reg | dec_wide[VALUE_BITS-1:0];
    assign dec_cnt   = cnt_reg + 4'd1;

    assign out_free   = !out_valid_reg || rsp_ready;
    assign step_emits = (work_op_reg == OP_ENCODE) || dec_full || !work_byte_reg[7];
    assign step_done  = (work_op_reg == OP_DECODE) || work_err_reg || (work_left_reg == 4'd1);
    assign step_go    = work_valid_reg && (!step_emits || out_free);
    assign req_ready  = !work_valid_reg || (step_go && step_done);
    assign accept     = req_valid && req_ready;

    always_comb
    begin
        result = '0;
        result.last = 1'b1;
        if (work_op_reg == OP_ENCODE)
        begin
            if (work_err_reg)
            begin
                result.kind = KIND_ERROR;
            end
            else
            begin
                result.kind     = KIND_BYTE;
                result.last     = work_left_reg == 4'd1;
                result.byte_out = {!result.last, work_val_reg[6:0]};
                result.length   = work_len_reg;
            end
        end
        else if (dec_full)
        begin
            result.kind = KIND_ERROR;
        end
        else
        begin
            result.kind      = KIND_VALUE;
            result.value_out = dec_acc;
            result.length    = dec_cnt;
        end
    end

    always_comb
    begin
        work_valid_next = work_valid_reg;
        work_op_next    = work_op_reg;
        work_err_next   = work_err_reg;
        work_val_next   = work_val_reg;
        work_byte_next  = work_byte_reg;
        work_len_next   = work_len_reg;
        work_left_next  = work_left_reg;
        acc_next        = acc_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;

        if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (step_go)
        begin
            if (step_emits)
            begin
                out_valid_next = 1'b1;
                out_next       = result;
            end
            if (work_op_reg == OP_ENCODE)
            begin
                acc_next       = '0;
                cnt_next       = 4'd0;
                work_val_next  = work_val_reg >> GROUP_BITS;
                work_left_next = work_left_reg - 4'd1;
            end
            else if (dec_full || !work_byte_reg[7])
            begin
                acc_next = '0;
                cnt_next = 4'd0;
            end
            else
            begin
                acc_next = dec_acc;
                cnt_next = dec_cnt;
            end
            if (step_done)
            begin
                work_valid_next = 1'b0;
            end
        end

        if (accept)
        begin
            work_valid_next = 1'b1;
            work_op_next    = req.op;
            work_err_next   = enc_err;
            work_val_next   = req.value_in;
            work_byte_next  = req.byte_in;
            work_len_next   = enc_len;
            work_left_next  = enc_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
            acc_reg        <= '0;
            cnt_reg        <= 4'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            work_valid_reg <= work_valid_next;
            acc_reg        <= acc_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_op_reg   <= work_op_next;
        work_err_reg  <= work_err_next;
        work_val_reg  <= work_val_next;
        work_byte_reg <= work_byte_next;
        work_len_reg  <= work_len_next;
        work_left_reg <= work_left_next;
        out_reg       <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= MAX_LEN)
        else $error("decode byte count exceeds its limit");

    a_enc_left: assert property (@(posedge clk) disable iff (!rst_n)
        work_valid_reg && (work_op_reg == OP_ENCODE) && !work_err_reg
        |-> (work_left_reg != 4'd0) && (work_left_reg <= work_len_reg))
        else $error("encode byte counter out of range");

    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.kind == KIND_ERROR)
        |-> rsp.last && (rsp.length == 4'd0) && (rsp.value_out == '0))
        else $error("malformed error result");

    a_dec_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        step_go && (work_op_reg == OP_DECODE) && dec_full
        |=> rsp_valid && (rsp.kind == KIND_ERROR) && (cnt_reg == 4'd0))
        else $error("decode overflow did not give an error");

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;

    import b128vc_pkg::*;

    localparam int MAX_BYTES    = 9;
    localparam int RANDOM_ITEMS = 140;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    b128vc_in_t  req;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    b128vc_out_t rsp;

    logic [62:0] acc_value;
    logic [3:0]  acc_bytes;
    b128vc_out_t awaited_results[$];

    bit idle_gaps = 1'b1;
    int stall_left = 0;
    int cycle_count = 0;
    int fail_count = 0;
    int items_sent = 0;
    int results_seen = 0;
    int bytes_seen = 0;
    int values_seen = 0;
    int errors_seen = 0;

    base128_varint_codec_top #(
        .MAX_BYTES(MAX_BYTES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp)
    );

    always #1 clk = ~clk;

    function automatic logic [62:0] rand63();
        return 63'({$urandom(), $urandom()});
    endfunction

    function automatic b128vc_out_t make_result(logic [1:0] kind, logic [7:0] data,
                                                logic [62:0] value, logic [3:0] len,
                                                logic fin);
        b128vc_out_t r;
        r.kind      = kind;
        r.byte_out  = data;
        r.value_out = value;
        r.length    = len;
        r.last      = fin;
        return r;
    endfunction

    function automatic void enqueue_result(b128vc_out_t r);
        awaited_results.insert(awaited_results.size(), r);
    endfunction

    // Updates the codec state for one accepted transaction and queues its results.
    function automatic void compute_varint_results(b128vc_in_t item);
        logic [62:0] rest;
        logic [7:0]  data;
        int          n;
        if (item.op == OP_ENCODE)
        begin
            acc_value = '0;
            acc_bytes = '0;
            rest = item.value_in >> 7;
            n = 1;
            while (rest != 0 && n < 9)
            begin
                rest = rest >> 7;
                n++;
            end
            if (n > MAX_BYTES)
            begin
                enqueue_result(make_result(KIND_ERROR, '0, '0, '0, 1'b1));
            end
            else
            begin
                for (int i = 0; i < n; i++)
                begin
                    data = {1'b0, 7'(item.value_in >> (7 * i))};
                    data[7] = (i != n - 1);
                    enqueue_result(make_result(KIND_BYTE, data, '0, 4'(n),
                                               i == n - 1));
                end
            end
        end
        else if (acc_bytes >= MAX_BYTES)
        begin
            acc_value = '0;
            acc_bytes = '0;
            enqueue_result(make_result(KIND_ERROR, '0, '0, '0, 1'b1));
        end
        else
        begin
            acc_value = acc_value | (63'(item.byte_in[6:0]) << (7 * acc_bytes));
            acc_bytes = acc_bytes + 4'd1;
            if (!item.byte_in[7])
            begin
                enqueue_result(make_result(KIND_VALUE, '0, acc_value,
                                           acc_bytes, 1'b1));
                acc_value = '0;
                acc_bytes = '0;
            end
        end
    endfunction

    // Called at a falling edge; returns at a falling edge with req_valid still high.
    task automatic send_item(input logic op, input logic [62:0] value,
                             input logic [7:0] data);
        b128vc_in_t item;
        bit         accepted;
        item.op       = op;
        item.value_in = (op == OP_ENCODE) ? value : rand63();
        item.byte_in  = (op == OP_DECODE) ? data : 8'($urandom());
        if (idle_gaps && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        accepted = 1'b0;
        while (!accepted)
        begin
            @(posedge clk);
            accepted = req_ready;
            if (accepted)
            begin
                compute_varint_results(item);
                items_sent++;
            end
            @(negedge clk);
        end
    endtask

    task automatic wait_drain();
        req_valid <= 1'b0;
        @(negedge clk);
        while (awaited_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_encode_edges();
        send_item(OP_ENCODE, 63'd0, '0);
        send_item(OP_ENCODE, 63'd127, '0);
        send_item(OP_ENCODE, 63'd128, '0);
        send_item(OP_ENCODE, {63{1'b1}}, '0);
    endtask

    task automatic test_decode_edges();
        send_item(OP_DECODE, '0, 8'h00);
        for (int i = 0; i < 8; i++)
            send_item(OP_DECODE, '0, 8'hFF);
        send_item(OP_DECODE, '0, 8'h7F);
    endtask

    task automatic test_decode_overflow();
        for (int i = 0; i < MAX_BYTES; i++)
            send_item(OP_DECODE, '0, 8'h80);
        send_item(OP_DECODE, '0, 8'h01);
    endtask

    task automatic test_encode_aborts_decode();
        send_item(OP_DECODE, '0, 8'h85);
        send_item(OP_ENCODE, 63'd300, '0);
        send_item(OP_DECODE, '0, 8'h05);
    endtask

    task automatic test_random_mix();
        int          start;
        int          n;
        logic [62:0] v;
        start = items_sent;
        while (items_sent < start + RANDOM_ITEMS)
        begin
            if (items_sent >= start + RANDOM_ITEMS - 30)
                idle_gaps = 1'b0;
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    n = $urandom_range(1, 9);
                    v = rand63();
                    if (n < 9)
                        v = v & ((63'd1 << (7 * n)) - 63'd1);
                    send_item(OP_ENCODE, v, '0);
                end
                4, 5, 6:
                begin
                    n = $urandom_range(1, 9);
                    for (int i = 0; i < n - 1; i++)
                        send_item(OP_DECODE, '0, {1'b1, 7'($urandom())});
                    send_item(OP_DECODE, '0, {1'b0, 7'($urandom())});
                end
                7:
                begin
                    n = $urandom_range(1, 8);
                    for (int i = 0; i < n; i++)
                        send_item(OP_DECODE, '0, {1'b1, 7'($urandom())});
                    send_item(OP_ENCODE, rand63(), '0);
                end
                8:
                begin
                    for (int i = 0; i < MAX_BYTES; i++)
                        send_item(OP_DECODE, '0, {1'b1, 7'($urandom())});
                    send_item(OP_DECODE, '0, 8'($urandom()));
                end
                default:
                    send_item(OP_DECODE, '0, 8'($urandom()));
            endcase
        end
    endtask

    always @(negedge clk)
    begin
        if (stall_left != 0)
            stall_left <= stall_left - 1;
        else if (idle_gaps && rst_n && $urandom_range(0, 5) == 0)
        begin
            rsp_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end
        else
            rsp_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        b128vc_out_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            results_seen++;
            case (rsp.kind)
                KIND_BYTE:  bytes_seen++;
                KIND_VALUE: values_seen++;
                KIND_ERROR: errors_seen++;
                default: ;
            endcase
            if (awaited_results.size() == 0)
            begin
                $error("unexpected result transaction: %p", rsp);
                fail_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (rsp.kind !== want.kind)
                begin
                    $error("kind: expected %0d, actual %0d", want.kind, rsp.kind);
                    fail_count++;
                end
                if (rsp.byte_out !== want.byte_out)
                begin
                    $error("byte_out: expected 0x%02h, actual 0x%02h",
                           want.byte_out, rsp.byte_out);
                    fail_count++;
                end
                if (rsp.value_out !== want.value_out)
                begin
                    $error("value_out: expected 0x%016h, actual 0x%016h",
                           want.value_out, rsp.value_out);
                    fail_count++;
                end
                if (rsp.length !== want.length)
                begin
                    $error("length: expected %0d, actual %0d", want.length, rsp.length);
                    fail_count++;
                end
                if (rsp.last !== want.last)
                begin
                    $error("last: expected %0d, actual %0d", want.last, rsp.last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        acc_value = '0;
        acc_bytes = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_encode_edges();
        test_decode_edges();
        wait_drain();
        test_decode_overflow();
        test_encode_aborts_decode();
        wait_drain();
        test_random_mix();

        wait_drain();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (awaited_results.size() != 0)
        begin
            $error("%0d expected results never arrived", awaited_results.size());
            fail_count++;
        end

        $display("Sent %0d transactions; checked %0d results: %0d encoded bytes,",
                 items_sent, results_seen, bytes_seen);
        $display("%0d decoded values and %0d overflow errors.", values_seen, errors_seen);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
